>>> rtl/polygon_perimeter_accumulator_assert.svh
// Assertion macros for the polygon perimeter accumulator.
`ifndef POLYGON_PERIMETER_ACCUMULATOR_ASSERT_SVH
`define POLYGON_PERIMETER_ACCUMULATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ppa_pkg.sv
// Shared widths, constants and types for the polygon perimeter accumulator.
package ppa_pkg;

  localparam int COORD_W = 24;            // Q15.8 vertex coordinate
  localparam int MAG_W   = COORD_W;       // |dx|, |dy| fit in 24 bits
  localparam int SQ_W    = 2 * MAG_W;     // one squared component
  localparam int ROOT_W  = MAG_W + 1;     // edge length, Q.8
  localparam int RAD_W   = 2 * ROOT_W;    // radicand, padded to even width
  localparam int REM_W   = ROOT_W + 2;    // partial remainder of the root
  localparam int ITER_W  = $clog2(ROOT_W);
  localparam int SUM_W   = 40;            // perimeter, Q32.8
  localparam int CNT_W   = 11;            // vertex count

  localparam int COUNT_MAX        = 2047;
  localparam int MAX_VERTICES_DEF = 1024;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

>>> rtl/ppa_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module ppa_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ppa_pkg::RAD_W-1:0]    radicand,
  output ppa_pkg::sq_stat_t            stat,
  output logic [ppa_pkg::ROOT_W-1:0]   root
);

  localparam logic [ppa_pkg::ITER_W-1:0] ITER_LAST = ppa_pkg::ITER_W'(ppa_pkg::ROOT_W - 1);

  logic [ppa_pkg::RAD_W-1:0]  rad;
  logic [ppa_pkg::REM_W-1:0]  rem;
  logic [ppa_pkg::ITER_W-1:0] iter;
  logic                       busy;
  logic                       done;

  logic [ppa_pkg::REM_W-1:0]  rem_sh;
  logic [ppa_pkg::REM_W-1:0]  trial;
  logic                       fits;

  // bring down the next two radicand bits, try (root << 2) | 1
  assign rem_sh = {rem[ppa_pkg::REM_W-3:0], rad[ppa_pkg::RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= busy && !start && (iter == ITER_LAST);
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == ITER_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[ppa_pkg::RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ppa_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

>>> rtl/polygon_perimeter_accumulator.sv
// Top level: vertex intake, edge sequencer, shared squarer, sum and result register.
//
// Input channel: x_coord, y_coord (signed Q15.8) and last_vertex, with
// in_valid / in_stall. Output channel: perimeter (Q32.8), vertex_count and
// overflow, with out_valid / out_stall. An item moves when valid is high
// and stall is low at a rising edge.
// The first vertex of a polygon is taken without raising in_stall. Each
// later vertex runs one edge: both components on the shared squarer, a
// load of the root unit, the root unit (one result bit per cycle), and the
// add of the length; in_stall stays high through the whole edge, so the
// next vertex is taken only after it.
// A marked vertex runs the closing edge as well and then loads the result
// register from ST_EMIT; a one-vertex polygon goes to ST_EMIT straight
// from accept. One item is in work at a time.
// The result register holds a finished perimeter while the receiver
// stalls, and the next vertex can be taken meanwhile; a following marked
// vertex waits before loading it until the register is free.
// Reset (rst, synchronous) clears the sum, count, stored vertices and out_valid
// (not the result data); the block is ready in the cycle after reset.
module polygon_perimeter_accumulator #(
  parameter int MAX_VERTICES = ppa_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [ppa_pkg::COORD_W-1:0] x_coord,
  input  logic signed [ppa_pkg::COORD_W-1:0] y_coord,
  input  logic                               last_vertex,
  input  logic                               in_valid,
  output logic                               in_stall,
  output logic [ppa_pkg::SUM_W-1:0]          perimeter,
  output logic [ppa_pkg::CNT_W-1:0]          vertex_count,
  output logic                               overflow,
  output logic                               out_valid,
  input  logic                               out_stall
);

  localparam int CAP_INT = (MAX_VERTICES < ppa_pkg::COUNT_MAX) ? MAX_VERTICES
                                                               : ppa_pkg::COUNT_MAX;
  localparam logic [ppa_pkg::CNT_W-1:0] COUNT_CAP = ppa_pkg::CNT_W'(CAP_INT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_EMIT
  } state_t;

  state_t state;

  logic signed [ppa_pkg::COORD_W-1:0] first_x;
  logic signed [ppa_pkg::COORD_W-1:0] first_y;
  logic signed [ppa_pkg::COORD_W-1:0] prev_x;
  logic signed [ppa_pkg::COORD_W-1:0] prev_y;
  logic [ppa_pkg::SUM_W-1:0]          running_sum;
  logic [ppa_pkg::CNT_W-1:0]          count_so_far;
  logic                               saturated_flag;
  logic                               need_close;
  logic                               need_emit;

  logic [ppa_pkg::MAG_W-1:0]  mag_x;
  logic [ppa_pkg::MAG_W-1:0]  mag_y;
  logic [ppa_pkg::SQ_W-1:0]   sq_x;
  logic [ppa_pkg::SQ_W-1:0]   sq_y;

  logic [ppa_pkg::MAG_W-1:0]  mul_op;
  logic [ppa_pkg::SQ_W-1:0]   prod;
  logic [ppa_pkg::RAD_W-1:0]  rad_in;
  logic                       sq_start;
  ppa_pkg::sq_stat_t          sq_stat;
  logic [ppa_pkg::ROOT_W-1:0] edge_len;
  logic [ppa_pkg::SUM_W:0]    sum_ext;
  logic                       in_take;
  logic                       out_free;

  function automatic logic [ppa_pkg::MAG_W-1:0] abs_diff(
    input logic signed [ppa_pkg::COORD_W-1:0] a,
    input logic signed [ppa_pkg::COORD_W-1:0] b
  );
    logic signed [ppa_pkg::COORD_W:0] d;
    d = {a[ppa_pkg::COORD_W-1], a} - {b[ppa_pkg::COORD_W-1], b};
    if (d[ppa_pkg::COORD_W]) begin
      d = -d;
    end
    return d[ppa_pkg::MAG_W-1:0];
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // single squarer shared by both components
  assign mul_op   = (state == ST_MUL_X) ? mag_x : mag_y;
  assign prod     = ppa_pkg::SQ_W'(mul_op) * ppa_pkg::SQ_W'(mul_op);
  assign rad_in   = ppa_pkg::RAD_W'(sq_x) + ppa_pkg::RAD_W'(sq_y);
  assign sq_start = (state == ST_ROOT_START);
  assign sum_ext  = {1'b0, running_sum} + (ppa_pkg::SUM_W + 1)'(edge_len);

  ppa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (rad_in),
    .stat     (sq_stat),
    .root     (edge_len)
  );

  always_ff @(posedge clk) begin
    if (state == ST_MUL_X) begin
      sq_x <= prod;
    end
    if (state == ST_MUL_Y) begin
      sq_y <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      first_x        <= '0;
      first_y        <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      running_sum    <= '0;
      count_so_far   <= '0;
      saturated_flag <= 1'b0;
      need_close     <= 1'b0;
      need_emit      <= 1'b0;
      mag_x          <= '0;
      mag_y          <= '0;
    end else begin
      // in ST_EMIT the result load below owns out_valid
      if (out_valid && !out_stall && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (count_so_far == '0) begin
              first_x <= x_coord;
              first_y <= y_coord;
              mag_x   <= '0;
              mag_y   <= '0;
            end else begin
              mag_x <= abs_diff(x_coord, prev_x);
              mag_y <= abs_diff(y_coord, prev_y);
            end
            prev_x <= x_coord;
            prev_y <= y_coord;
            if (count_so_far >= COUNT_CAP) begin
              count_so_far   <= COUNT_CAP;
              saturated_flag <= 1'b1;
            end else begin
              count_so_far <= count_so_far + 1'b1;
            end
            need_close <= last_vertex && (count_so_far != '0);
            need_emit  <= last_vertex;
            if (count_so_far != '0) begin
              state <= ST_MUL_X;
            end else if (last_vertex) begin
              // lone vertex: perimeter stays zero
              state <= ST_EMIT;
            end
          end
        end
        ST_MUL_X: begin
          state <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          state <= ST_ROOT_START;
        end
        ST_ROOT_START: begin
          state <= ST_ROOT_WAIT;
        end
        ST_ROOT_WAIT: begin
          if (sq_stat.done) begin
            if (sum_ext[ppa_pkg::SUM_W]) begin
              running_sum    <= '1;
              saturated_flag <= 1'b1;
            end else begin
              running_sum <= sum_ext[ppa_pkg::SUM_W-1:0];
            end
            if (need_close) begin
              // closing edge from the last vertex back to the first
              mag_x      <= abs_diff(first_x, prev_x);
              mag_y      <= abs_diff(first_y, prev_y);
              need_close <= 1'b0;
              state      <= ST_MUL_X;
            end else if (need_emit) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            perimeter      <= running_sum;
            vertex_count   <= count_so_far;
            overflow       <= saturated_flag;
            out_valid      <= 1'b1;
            first_x        <= '0;
            first_y        <= '0;
            prev_x         <= '0;
            prev_y         <= '0;
            running_sum    <= '0;
            count_so_far   <= '0;
            saturated_flag <= 1'b0;
            need_emit      <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "polygon_perimeter_accumulator_assert.svh"

  `PPA_ASSERT_NOW(a_count_capped, out_valid, vertex_count <= COUNT_CAP, "vertex count above cap")
  `PPA_ASSERT_NOW(a_root_done_wait, sq_stat.done, state == ST_ROOT_WAIT, "root done out of sequence")
  `PPA_ASSERT_NEXT(a_emit_clears, (state == ST_EMIT) && out_free, out_valid && (count_so_far == '0) && (running_sum == '0), "state not cleared on result")
  `PPA_ASSERT_NOW(a_root_busy_state, sq_stat.busy, state == ST_ROOT_WAIT, "root unit busy outside wait")

endmodule
